### rtl/bounded_unique_set_with_rank_top_defines.svh
// ----------------------------------------------------------------------------
// bounded unique set with rank - assertion macros
// concurrent assertion helpers on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BOUNDED_UNIQUE_SET_WITH_RANK_TOP_DEFINES_SVH
`define BOUNDED_UNIQUE_SET_WITH_RANK_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define BUSR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BUSR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BUSR_ASSERT_IMP(label, ante, cons, msg)
`define BUSR_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

### rtl/busr_pkg.sv
// ----------------------------------------------------------------------------
// busr_pkg
// shared widths, request kinds, controller states and command/status bundles
// ----------------------------------------------------------------------------
package busr_pkg;

    localparam int REQ_TYPE_W = 2;
    localparam int ITEM_W     = 32;
    localparam int RANK_W     = 6;
    localparam int COUNT_W    = 7;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_INSERT   = 2'd0,
        REQ_ERASE    = 2'd1,
        REQ_CONTAINS = 2'd2,
        REQ_GET      = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_FIND,
        ST_SHIFT,
        ST_OUTER_RD,
        ST_OUTER_LAT,
        ST_INNER,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_req;
        logic scan_start;
        logic scan;
        logic shift_start;
        logic shift_wr;
        logic outer_rd;
        logic outer_latch;
        logic outer_next;
        logic ins_write;
        logic fill_dec;
        logic res_set;
        logic res_ok;
        logic res_cand;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        req_kind_t kind;
        logic      hit;
        logic      scan_done;
        logic      rank_ok;
        logic      full;
        logic      empty;
        logic      rank_match;
        logic      out_free;
    } sts_t;

endpackage

### rtl/busr_req_if.sv
// ----------------------------------------------------------------------------
// busr_req_if
// request channel: valid/ready handshake with request kind, item and rank
// ----------------------------------------------------------------------------
interface busr_req_if;

    logic                            valid;
    logic                            ready;
    logic [busr_pkg::REQ_TYPE_W-1:0] req_type;
    logic [busr_pkg::ITEM_W-1:0]     item;
    logic [busr_pkg::RANK_W-1:0]     rank;

    modport source (output valid, output req_type, output item, output rank, input ready);
    modport sink   (input valid, input req_type, input item, input rank, output ready);

endinterface

### rtl/busr_rsp_if.sv
// ----------------------------------------------------------------------------
// busr_rsp_if
// result channel: valid/ready handshake with flag, item and count
// ----------------------------------------------------------------------------
interface busr_rsp_if;

    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [busr_pkg::ITEM_W-1:0]  item_out;
    logic [busr_pkg::COUNT_W-1:0] count;

    modport source (output valid, output ok, output item_out, output count, input ready);
    modport sink   (input valid, input ok, input item_out, input count, output ready);

endinterface

### rtl/busr_ram.sv
// ----------------------------------------------------------------------------
// busr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module busr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/busr_datapath.sv
// ----------------------------------------------------------------------------
// busr_datapath
// entry store, scan counters, compare logic, fill count and result register
// ----------------------------------------------------------------------------
module busr_datapath #(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  busr_pkg::cmd_t                  cmd,
    output busr_pkg::sts_t                  sts,
    input  logic [busr_pkg::REQ_TYPE_W-1:0] req_type,
    input  logic [busr_pkg::ITEM_W-1:0]     item,
    input  logic [busr_pkg::RANK_W-1:0]     rank,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            ok,
    output logic [busr_pkg::ITEM_W-1:0]     item_out,
    output logic [busr_pkg::COUNT_W-1:0]    count
);

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int FILL_W  = $clog2(CAPACITY + 1);
    localparam int RankW   = busr_pkg::RANK_W;
    localparam int CMP_W   = (FILL_W > RankW) ? FILL_W : RankW;
    localparam int ItemW   = busr_pkg::ITEM_W;
    localparam int CountW  = busr_pkg::COUNT_W;

    busr_pkg::req_kind_t   kind_reg;
    logic [ITEM_WIDTH-1:0] item_reg;
    logic [RankW-1:0]      rank_reg;
    logic [FILL_W-1:0]     fill_reg,    fill_next;
    logic [FILL_W-1:0]     j_reg,       j_next;
    logic                  pend_reg,    pend_next;
    logic [ADDR_W-1:0]     pend_idx_reg;
    logic [ADDR_W-1:0]     i_reg;
    logic [ITEM_WIDTH-1:0] cand_reg;
    logic [FILL_W-1:0]     smaller_reg, smaller_next;
    logic                  res_ok_reg;
    logic [ITEM_WIDTH-1:0] res_item_reg;
    logic                  out_vld_reg;
    logic                  out_ok_reg;
    logic [ItemW-1:0]      out_item_reg;
    logic [CountW-1:0]     out_count_reg;

    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ITEM_WIDTH-1:0] rd_data;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ITEM_WIDTH-1:0] wr_data;
    logic                  issue;

    busr_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // memory port control
    assign issue   = cmd.scan && (j_reg < fill_reg);
    assign rd_en   = issue || cmd.outer_rd;
    assign rd_addr = cmd.outer_rd ? i_reg : j_reg[ADDR_W-1:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = fill_reg[ADDR_W-1:0];
        wr_data = item_reg;
        if (cmd.ins_write)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.shift_wr && pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_idx_reg - ADDR_W'(1);
            wr_data = rd_data;
        end
    end

    // scan counter and compare pipeline
    always_comb
    begin
        j_next       = j_reg;
        pend_next    = issue;
        smaller_next = smaller_reg;
        if (issue)
        begin
            j_next = j_reg + FILL_W'(1);
        end
        if (cmd.load_req || cmd.scan_start)
        begin
            j_next    = '0;
            pend_next = 1'b0;
        end
        else if (cmd.shift_start)
        begin
            j_next    = FILL_W'(pend_idx_reg) + FILL_W'(1);
            pend_next = 1'b0;
        end
        if (cmd.scan_start)
        begin
            smaller_next = '0;
        end
        else if (pend_reg && (rd_data < cand_reg))
        begin
            smaller_next = smaller_reg + FILL_W'(1);
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.ins_write)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (cmd.fill_dec)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            j_reg       <= '0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            j_reg    <= j_next;
            pend_reg <= pend_next;
            if (cmd.out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        smaller_reg <= smaller_next;
        if (issue)
        begin
            pend_idx_reg <= j_reg[ADDR_W-1:0];
        end
        if (cmd.load_req)
        begin
            kind_reg <= busr_pkg::req_kind_t'(req_type);
            item_reg <= ITEM_WIDTH'(item);
            rank_reg <= rank;
            i_reg    <= '0;
        end
        else if (cmd.outer_next)
        begin
            i_reg <= i_reg + ADDR_W'(1);
        end
        if (cmd.outer_latch)
        begin
            cand_reg <= rd_data;
        end
        if (cmd.res_set)
        begin
            res_ok_reg   <= cmd.res_ok;
            res_item_reg <= cmd.res_cand ? cand_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_ok_reg    <= res_ok_reg;
            out_item_reg  <= ItemW'(res_item_reg);
            out_count_reg <= CountW'(fill_reg);
        end
    end

    // status back to the controller
    always_comb
    begin
        sts.kind       = kind_reg;
        sts.hit        = pend_reg && (rd_data == item_reg);
        sts.scan_done  = !pend_reg && (j_reg == fill_reg);
        sts.rank_ok    = CMP_W'(rank_reg) < CMP_W'(fill_reg);
        sts.full       = fill_reg == FILL_W'(CAPACITY);
        sts.empty      = fill_reg == '0;
        sts.rank_match = CMP_W'(smaller_reg) == CMP_W'(rank_reg);
        sts.out_free   = !out_vld_reg || out_ready;
    end

    assign out_valid = out_vld_reg;
    assign ok        = out_ok_reg;
    assign item_out  = out_item_reg;
    assign count     = out_count_reg;

endmodule

### rtl/busr_ctrl.sv
// ----------------------------------------------------------------------------
// busr_ctrl
// request sequencer: lookup scan, erase shift and rank selection passes
// ----------------------------------------------------------------------------
module busr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output busr_pkg::cmd_t cmd,
    input  busr_pkg::sts_t sts
);

    busr_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= busr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            busr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = busr_pkg::ST_START;
                end
            end
            busr_pkg::ST_START:
            begin
                if (sts.kind == busr_pkg::REQ_GET)
                begin
                    state_next = sts.rank_ok ? busr_pkg::ST_OUTER_RD : busr_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = busr_pkg::ST_FIND;
                end
            end
            busr_pkg::ST_FIND:
            begin
                if (sts.hit)
                begin
                    state_next = (sts.kind == busr_pkg::REQ_ERASE) ? busr_pkg::ST_SHIFT
                                                                   : busr_pkg::ST_FINISH;
                end
                else if (sts.scan_done)
                begin
                    state_next = busr_pkg::ST_FINISH;
                end
            end
            busr_pkg::ST_SHIFT:
            begin
                if (sts.scan_done)
                begin
                    state_next = busr_pkg::ST_FINISH;
                end
            end
            busr_pkg::ST_OUTER_RD:
            begin
                state_next = busr_pkg::ST_OUTER_LAT;
            end
            busr_pkg::ST_OUTER_LAT:
            begin
                state_next = busr_pkg::ST_INNER;
            end
            busr_pkg::ST_INNER:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.rank_match ? busr_pkg::ST_FINISH : busr_pkg::ST_OUTER_RD;
                end
            end
            busr_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = busr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = busr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            busr_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            busr_pkg::ST_START:
            begin
                if ((sts.kind == busr_pkg::REQ_GET) && !sts.rank_ok)
                begin
                    cmd.res_set = 1'b1;
                end
            end
            busr_pkg::ST_FIND:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                begin
                    if (sts.kind == busr_pkg::REQ_ERASE)
                    begin
                        cmd.shift_start = 1'b1;
                    end
                    else
                    begin
                        cmd.res_set = 1'b1;
                        cmd.res_ok  = (sts.kind == busr_pkg::REQ_CONTAINS);
                    end
                end
                else if (sts.scan_done)
                begin
                    cmd.res_set = 1'b1;
                    if ((sts.kind == busr_pkg::REQ_INSERT) && !sts.full)
                    begin
                        cmd.ins_write = 1'b1;
                        cmd.res_ok    = 1'b1;
                    end
                end
            end
            busr_pkg::ST_SHIFT:
            begin
                cmd.scan     = 1'b1;
                cmd.shift_wr = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.fill_dec = 1'b1;
                    cmd.res_set  = 1'b1;
                    cmd.res_ok   = 1'b1;
                end
            end
            busr_pkg::ST_OUTER_RD:
            begin
                cmd.outer_rd = 1'b1;
            end
            busr_pkg::ST_OUTER_LAT:
            begin
                cmd.outer_latch = 1'b1;
                cmd.scan_start  = 1'b1;
            end
            busr_pkg::ST_INNER:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    if (sts.rank_match)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_ok   = 1'b1;
                        cmd.res_cand = 1'b1;
                    end
                    else
                    begin
                        cmd.outer_next = 1'b1;
                    end
                end
            end
            busr_pkg::ST_FINISH:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/bounded_unique_set_with_rank_top.sv
// ----------------------------------------------------------------------------
// bounded_unique_set_with_rank_top
// bounded set of distinct items with insert, erase, contains and get by rank
//
// channel   role   carries
// req       sink   req_type, item, rank
// rsp       source ok, item_out, count
//
// insert, contains and erase scan the stored items in order; a hit erase then
// shifts the later entries down; get tries candidates in order, each with a
// full scan that counts the smaller items, all through the single read port
// of the entry store
// reset empties the set at once, with no clearing pass
// a finished result sits in the output register while the next request
// is taken; a request ends only once that register is free
// ----------------------------------------------------------------------------
`include "bounded_unique_set_with_rank_top_defines.svh"

module bounded_unique_set_with_rank_top #(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    busr_req_if.sink    req,
    busr_rsp_if.source  rsp
);

    busr_pkg::cmd_t cmd;
    busr_pkg::sts_t sts;

    busr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    busr_datapath #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_type  (req.req_type),
        .item      (req.item),
        .rank      (req.rank),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ok        (rsp.ok),
        .item_out  (rsp.item_out),
        .count     (rsp.count)
    );

    `BUSR_ASSERT_IMP(a_insert_not_full, cmd.ins_write, !sts.full, "insert write with the store full")
    `BUSR_ASSERT_IMP(a_erase_not_empty, cmd.fill_dec, !sts.empty, "erase with the store empty")
    `BUSR_ASSERT_IMP(a_result_slot_free, cmd.out_load, sts.out_free, "result overwrites a pending one")
    `BUSR_ASSERT_NXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "request taken while busy")

endmodule
